[rtl/dtsm_pkg.sv]
// ----------------------------------------------------------------------------
// dtsm_pkg
// Shared types, constants and helpers for the signature matcher core:
// signature table, window geometry, result bit positions and the history
// cell control bundle.
// ----------------------------------------------------------------------------
package dtsm_pkg;

    // Window geometry: current byte plus eleven history bytes
    localparam int unsigned HIST_DEPTH = 11;
    localparam int unsigned WIN_BYTES  = HIST_DEPTH + 1;
    localparam int unsigned WIN_W      = 8 * WIN_BYTES;

    // Signature table layout: rules first, then pipe-to-shell strings
    localparam int unsigned RULE_COUNT = 25;
    localparam int unsigned PIPE_COUNT = 4;
    localparam int unsigned SIG_COUNT  = RULE_COUNT + PIPE_COUNT;

    // Result layout
    localparam int unsigned CURL_BIT   = 8;
    localparam int unsigned WGET_BIT   = 9;
    localparam int unsigned PIPE_BIT   = 25;
    localparam int unsigned MASK_W     = 26;
    localparam int unsigned OUT_DATA_W = 32;

    typedef logic [WIN_W-1:0] t_window;
    typedef logic [3:0]       t_sig_len;

    // Control bundle handed down the history chain
    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic clear;   // return to zero (end of text)
    } t_cell_ctrl;

    // Signatures, right-justified: last character in bits [7:0]
    localparam t_window SIG_TEXT [SIG_COUNT] = '{
        WIN_W'("system("),     WIN_W'("popen("),   WIN_W'("execv"),
        WIN_W'("execl"),       WIN_W'("spawn"),    WIN_W'("fork("),
        WIN_W'(":(){"),        WIN_W'(":|:&"),     WIN_W'("curl"),
        WIN_W'("wget"),        WIN_W'("socket("),  WIN_W'("connect("),
        WIN_W'("bind("),       WIN_W'("rm -rf"),   WIN_W'("mkfs"),
        WIN_W'("dd if="),      WIN_W'("shutdown"), WIN_W'("reboot"),
        WIN_W'("/etc/passwd"), WIN_W'("/etc/shadow"),
        WIN_W'("setuid"),      WIN_W'("sudo"),     WIN_W'("dlopen"),
        WIN_W'("__asm"),       WIN_W'("asm volatile"),
        WIN_W'("| sh"),        WIN_W'("|sh"),      WIN_W'("| bash"),
        WIN_W'("|bash")
    };

    localparam t_sig_len SIG_LEN [SIG_COUNT] = '{
        4'd7, 4'd6, 4'd5, 4'd5, 4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd7, 4'd8, 4'd5, 4'd6, 4'd4, 4'd6, 4'd8, 4'd6, 4'd11, 4'd11,
        4'd6, 4'd4, 4'd6, 4'd5, 4'd12,
        4'd4, 4'd3, 4'd6, 4'd5
    };

    // ASCII upper case to lower case, everything else unchanged
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Compare the newest len bytes of the window against one signature
    function automatic logic sig_hit(input t_window win, input t_window sig,
                                     input t_sig_len len);
        logic hit;
        hit = 1'b1;
        for (int j = 0; j < WIN_BYTES; j++) begin
            if (j < int'(len) && win[8*j +: 8] != sig[8*j +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

[rtl/dtsm_cell.sv]
// ----------------------------------------------------------------------------
// dtsm_cell
// One byte of the text history. Takes its neighbor's byte on a shift and
// hands its own byte to the next cell; clears at end of text.
// ----------------------------------------------------------------------------
module dtsm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtsm_pkg::t_cell_ctrl  i_ctrl,
    input  logic [7:0]            i_byte,
    output logic [7:0]            o_byte
);
    import dtsm_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Next byte: clear wins over shift
    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.clear) begin
            n_byte = '0;
        end else if (i_ctrl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

[rtl/dangerous_token_signature_matcher_core.sv]
// Result: the findings mask is valid in the cycle after the last byte's transaction.
// Throughput: one byte per cycle while s_tready is high; every signature is
//   compared against the eleven-cell history plus the incoming byte in that cycle.
// A result waiting in the output register does not stall input while the
//   master side takes it in the same cycle.
// Reset (synchronous, active low) clears history, sticky hits and output valid.
// ----------------------------------------------------------------------------
// dangerous_token_signature_matcher_core
// Case-insensitive multi-signature scanner over a byte stream. Keeps sticky
// per-rule hit bits and emits a 26-bit findings mask on the last byte.
// ----------------------------------------------------------------------------
module dangerous_token_signature_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [dtsm_pkg::OUT_DATA_W-1:0] m_tdata  // [25:0] findings_mask, rest zero
);
    import dtsm_pkg::*;

    logic                  w_s_acc;
    logic [7:0]            w_cur;
    t_cell_ctrl            w_ctrl;
    logic [7:0]            w_hist [HIST_DEPTH];
    t_window               w_win;
    logic [SIG_COUNT-1:0]  w_sig_hit;
    logic [RULE_COUNT-1:0] w_hits_all;
    logic                  w_pipe_all;
    logic [MASK_W-1:0]     w_mask;

    logic [RULE_COUNT-1:0] r_hits;
    logic [RULE_COUNT-1:0] n_hits;
    logic                  r_pipe;
    logic                  n_pipe;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [MASK_W-1:0]     r_out_mask;
    logic [MASK_W-1:0]     n_out_mask;

    // Input handshake: free slot or slot emptying this cycle
    assign s_tready = !r_out_valid || m_tready;
    assign w_s_acc  = s_tvalid && s_tready;
    assign w_cur    = to_lower(s_tdata);

    assign w_ctrl.shift = w_s_acc && !s_tlast;
    assign w_ctrl.clear = w_s_acc && s_tlast;

    // History chain and match window (current byte lowest)
    assign w_win[7:0] = w_cur;
    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_hist
        if (k == 0) begin : g_head
            dtsm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_byte  (w_cur),
                .o_byte  (w_hist[k])
            );
        end else begin : g_body
            dtsm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_byte  (w_hist[k-1]),
                .o_byte  (w_hist[k])
            );
        end
        assign w_win[8*(k+1) +: 8] = w_hist[k];
    end

    // Comparator row, one per signature
    for (genvar s = 0; s < SIG_COUNT; s++) begin : g_sig
        assign w_sig_hit[s] = sig_hit(w_win, SIG_TEXT[s], SIG_LEN[s]);
    end

    assign w_hits_all = r_hits | w_sig_hit[RULE_COUNT-1:0];
    assign w_pipe_all = r_pipe | (|w_sig_hit[SIG_COUNT-1:RULE_COUNT]);
    assign w_mask     = {w_pipe_all && (w_hits_all[CURL_BIT] || w_hits_all[WGET_BIT]),
                         w_hits_all};

    // Sticky hits and output register
    always_comb begin
        n_hits      = r_hits;
        n_pipe      = r_pipe;
        n_out_valid = r_out_valid && !m_tready;
        n_out_mask  = r_out_mask;
        if (w_s_acc) begin
            if (s_tlast) begin
                n_hits      = '0;
                n_pipe      = 1'b0;
                n_out_valid = 1'b1;
                n_out_mask  = w_mask;
            end else begin
                n_hits = w_hits_all;
                n_pipe = w_pipe_all;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_pipe      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hits      <= n_hits;
            r_pipe      <= n_pipe;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_mask <= n_out_mask;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_DATA_W-MASK_W){1'b0}}, r_out_mask};

    // Last byte leaves clean sticky state behind
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && s_tlast |=> r_hits == '0 && !r_pipe)
        else $error("sticky state not cleared after last byte");

    // Last byte always produces a result
    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    // Pipe-to-shell finding needs a download rule
    a_pipe_needs_dl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[PIPE_BIT] |-> m_tdata[CURL_BIT] || m_tdata[WGET_BIT])
        else $error("pipe finding without curl or wget");

    // History head follows the lowercased accepted byte
    a_hist_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && !s_tlast |=> w_hist[0] == $past(w_cur))
        else $error("history head does not hold the last accepted byte");

endmodule
